[design/bult_pkg.sv]
// Shared types and constants for the block undo log tracker.
// Holds the transaction payload structs, status and opcode codes, and the
// command and status bundles passed between controller and datapath.
package bult_pkg;

  localparam int LOG_DEPTH   = 256;
  localparam int BLOCK_COUNT = 65536;

  localparam int BLOCK_W     = 16;
  localparam int SLOT_W      = 8;
  localparam int LIMIT_W     = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 9;

  localparam int LOG_AW   = $clog2(LOG_DEPTH);
  localparam int COUNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int BLOCK_AW = $clog2(BLOCK_COUNT);

  // The saved-block bitmap is kept as rows of MARK_W bits.
  localparam int MARK_W     = 64;
  localparam int MARK_BIT_W = $clog2(MARK_W);
  localparam int MARK_ROWS  = BLOCK_COUNT / MARK_W;
  localparam int MARK_AW    = $clog2(MARK_ROWS);

  localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_MODE    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY_LIMIT = CFG_INDEX_W'(1);

  localparam logic               BITMAP_MODE_RESET    = 1'b1;
  localparam logic [LIMIT_W-1:0] CAPACITY_LIMIT_RESET = LIMIT_W'(256);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_POP   = 1'b1
  } opcode_t;

  typedef enum logic [2:0] {
    ST_ALREADY = 3'd0,
    ST_SAVE    = 3'd1,
    ST_FULL    = 3'd2,
    ST_RESTORE = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [BLOCK_W-1:0]   block_number;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [BLOCK_W-1:0]   restore_block;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic clear_row;
    logic scan_start;
    logic scan_step;
    logic decide;
    logic res_empty;
    logic pop_latch;
    logic pop_commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic op_pop;
    logic count_zero;
    logic bitmap_mode;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

[design/bult_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing else in the project.
module bult_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/bult_dp.sv]
// Datapath of the block undo log tracker: configuration registers, log fill,
// bitmap and log memories, linear search and the result register.
// Depends on bult_pkg and bult_ram.
module bult_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  bult_pkg::cmd_t                   cmd,
  output bult_pkg::sts_t                   sts,
  input  bult_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bult_pkg::result_t                result,
  input  logic                             cfg_valid,
  input  logic [bult_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bult_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                              mode;
  logic [bult_pkg::LIMIT_W-1:0]      limit;
  logic [bult_pkg::COUNT_W-1:0]      count;
  logic [bult_pkg::COUNT_W-1:0]      count_dec;
  logic [bult_pkg::MARK_AW-1:0]      clr_idx;
  bult_pkg::opcode_t                 op_reg;
  logic [bult_pkg::BLOCK_W-1:0]      block_reg;
  logic [bult_pkg::BLOCK_W-1:0]      rblock_reg;
  logic [bult_pkg::COUNT_W-1:0]      scan_idx;
  logic                              scan_pend;
  logic                              found;
  bult_pkg::result_t                 res;

  logic [bult_pkg::BLOCK_W-1:0]      mark_block;
  logic [bult_pkg::MARK_W-1:0]       bit_mask;
  logic [bult_pkg::MARK_AW-1:0]      mark_addr;
  logic [bult_pkg::MARK_W-1:0]       mark_rdata;
  logic [bult_pkg::MARK_W-1:0]       mark_wdata;
  logic                              mark_we;
  logic [bult_pkg::LOG_AW-1:0]       log_raddr;
  logic [bult_pkg::BLOCK_W-1:0]      log_rdata;

  logic saved;
  logic full;
  logic save_now;
  logic match_now;
  logic scan_issue;

  localparam logic [bult_pkg::MARK_AW-1:0] CLR_LAST =
    bult_pkg::MARK_AW'(bult_pkg::MARK_ROWS - 1);

  assign count_dec  = count - bult_pkg::COUNT_W'(1);
  assign mark_block = (op_reg == bult_pkg::OP_POP) ? rblock_reg : block_reg;
  assign bit_mask   = bult_pkg::MARK_W'(1) << mark_block[bult_pkg::MARK_BIT_W-1:0];
  assign mark_addr  = cmd.clear_row ? clr_idx
                    : mark_block[bult_pkg::BLOCK_AW-1:bult_pkg::MARK_BIT_W];

  assign saved    = mode ? mark_rdata[block_reg[bult_pkg::MARK_BIT_W-1:0]] : found;
  assign full     = (count >= bult_pkg::COUNT_W'(limit))
                 || (count >= bult_pkg::COUNT_W'(bult_pkg::LOG_DEPTH));
  assign save_now = cmd.decide && !saved && !full;

  assign mark_we    = cmd.clear_row || save_now || cmd.pop_commit;
  assign mark_wdata = cmd.clear_row ? '0
                    : save_now      ? (mark_rdata | bit_mask)
                    :                 (mark_rdata & ~bit_mask);

  assign log_raddr  = cmd.scan_step ? scan_idx[bult_pkg::LOG_AW-1:0]
                                    : count_dec[bult_pkg::LOG_AW-1:0];

  assign match_now  = scan_pend && (log_rdata == block_reg);
  assign scan_issue = cmd.scan_step && (scan_idx < count) && !match_now;

  assign sts.clear_last  = (clr_idx == CLR_LAST);
  assign sts.op_pop      = (op_reg == bult_pkg::OP_POP);
  assign sts.count_zero  = (count == '0);
  assign sts.bitmap_mode = mode;
  assign sts.scan_done   = match_now || (!scan_pend && (scan_idx >= count));
  assign sts.out_free    = !result_valid || !result_stall;

  bult_ram #(
    .WIDTH(bult_pkg::MARK_W),
    .DEPTH(bult_pkg::MARK_ROWS)
  ) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_addr),
    .wdata(mark_wdata),
    .raddr(mark_addr),
    .rdata(mark_rdata)
  );

  bult_ram #(
    .WIDTH(bult_pkg::BLOCK_W),
    .DEPTH(bult_pkg::LOG_DEPTH)
  ) u_log_ram (
    .clk  (clk),
    .we   (save_now),
    .waddr(count[bult_pkg::LOG_AW-1:0]),
    .wdata(block_reg),
    .raddr(log_raddr),
    .rdata(log_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= bult_pkg::BITMAP_MODE_RESET;
      limit        <= bult_pkg::CAPACITY_LIMIT_RESET;
      count        <= '0;
      clr_idx      <= '0;
      scan_pend    <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          bult_pkg::CFG_BITMAP_MODE:    mode  <= cfg_data[0];
          bult_pkg::CFG_CAPACITY_LIMIT: limit <= cfg_data[bult_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (save_now) begin
        count <= count + bult_pkg::COUNT_W'(1);
      end else if (cmd.pop_commit) begin
        count <= count_dec;
      end
      if (cmd.clear_row) begin
        clr_idx <= clr_idx + bult_pkg::MARK_AW'(1);
      end
      if (cmd.scan_start) begin
        scan_pend <= 1'b0;
        found     <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_pend <= scan_issue;
        if (match_now) begin
          found <= 1'b1;
        end
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_reg    <= item.opcode;
      block_reg <= item.block_number;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (scan_issue) begin
      scan_idx <= scan_idx + bult_pkg::COUNT_W'(1);
    end
    if (cmd.pop_latch) begin
      rblock_reg <= log_rdata;
    end
    if (cmd.decide) begin
      res.restore_block <= '0;
      if (saved) begin
        res.status <= bult_pkg::ST_ALREADY;
        res.slot   <= '0;
      end else if (full) begin
        res.status <= bult_pkg::ST_FULL;
        res.slot   <= '0;
      end else begin
        res.status <= bult_pkg::ST_SAVE;
        res.slot   <= count[bult_pkg::SLOT_W-1:0];
      end
    end else if (cmd.res_empty) begin
      res.status        <= bult_pkg::ST_EMPTY;
      res.slot          <= '0;
      res.restore_block <= '0;
    end else if (cmd.pop_commit) begin
      res.status        <= bult_pkg::ST_RESTORE;
      res.slot          <= count_dec[bult_pkg::SLOT_W-1:0];
      res.restore_block <= rblock_reg;
    end
    if (cmd.out_load) begin
      result <= res;
    end
  end

endmodule

[design/bult_ctrl.sv]
// Controller state machine of the block undo log tracker.
// Sequences bitmap clearing, lookups, log updates and result hand-off.
// Depends on bult_pkg.
module bult_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  bult_pkg::sts_t sts,
  output bult_pkg::cmd_t cmd
);

  typedef enum logic [9:0] {
    S_CLEAR     = 10'b00_0000_0001,
    S_IDLE      = 10'b00_0000_0010,
    S_CHECK     = 10'b00_0000_0100,
    S_SCAN      = 10'b00_0000_1000,
    S_DECIDE    = 10'b00_0001_0000,
    S_POP_READ  = 10'b00_0010_0000,
    S_POP_DATA  = 10'b00_0100_0000,
    S_POP_MARK  = 10'b00_1000_0000,
    S_POP_WRITE = 10'b01_0000_0000,
    S_OUTQ      = 10'b10_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_stall = 1'b1;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.op_pop) begin
          if (sts.count_zero) begin
            cmd.res_empty = 1'b1;
            state_next    = S_OUTQ;
          end else begin
            state_next = S_POP_READ;
          end
        end else if (sts.bitmap_mode) begin
          state_next = S_DECIDE;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_OUTQ;
      end
      S_POP_READ: begin
        state_next = S_POP_DATA;
      end
      S_POP_DATA: begin
        cmd.pop_latch = 1'b1;
        state_next    = S_POP_MARK;
      end
      S_POP_MARK: begin
        state_next = S_POP_WRITE;
      end
      S_POP_WRITE: begin
        cmd.pop_commit = 1'b1;
        state_next     = S_OUTQ;
      end
      S_OUTQ: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/block_undo_log_tracker.sv]
// Top level of the block undo log tracker.
// Joins the controller (bult_ctrl) and the datapath (bult_dp); uses bult_pkg.
//
// Each item transaction carries an opcode and a block number: a write notice
// is answered with already saved, save now with the next log slot, or log
// full; a restore pop returns the newest log entry or reports log empty.
// Exactly one result transaction follows each item, in order.
// Configuration writes (bitmap_mode, capacity_limit) are always ready and
// should only be issued while no item is in flight.
// In list mode a write notice searches the log, which is read one entry a
// cycle. One item is in progress at a time, so a new item is taken in the
// cycle after the previous result has moved to the output register.
// After reset the bitmap memory is cleared one 64-bit row a cycle, during
// which items are stalled. A stalled result is held in the output register;
// one further item may be worked on meanwhile and waits until that register
// is free.
module block_undo_log_tracker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_stall,
  input  bult_pkg::item_t                  item,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bult_pkg::result_t                result,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bult_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bult_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bult_pkg::cmd_t cmd;
  bult_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bult_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bult_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

endmodule

[dv/bult_answer_checker.sv]
// Checker for the block undo log tracker: watches the item, result and
// configuration channels, predicts each answer and compares it on arrival.
// Depends on the types and constants of bult_pkg.
module bult_answer_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  input  logic                             item_stall,
  input  bult_pkg::item_t                  item,
  input  logic                             result_valid,
  input  logic                             result_stall,
  input  bult_pkg::result_t                result,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [bult_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bult_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               failures,
  output int                               outstanding
);

  bit                           saved_mark [bult_pkg::BLOCK_COUNT];
  logic [bult_pkg::BLOCK_W-1:0] log_mem [bult_pkg::LOG_DEPTH];
  int unsigned                  fill;
  bit                           scan_by_bitmap;
  logic [bult_pkg::LIMIT_W-1:0] cap_limit;
  bult_pkg::result_t            awaited_answers [$];
  bult_pkg::result_t            want;

  function automatic bult_pkg::result_t undo_log_answer(bult_pkg::item_t it);
    bult_pkg::result_t r;
    int unsigned       cap;
    bit                found;
    r = '0;
    if (it.opcode == bult_pkg::OP_WRITE) begin
      cap = (cap_limit < bult_pkg::LOG_DEPTH) ? cap_limit : bult_pkg::LOG_DEPTH;
      found = 1'b0;
      if (scan_by_bitmap) begin
        found = saved_mark[it.block_number];
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (log_mem[i] == it.block_number) found = 1'b1;
        end
      end
      if (found) begin
        r.status = bult_pkg::ST_ALREADY;
      end else if (fill >= cap) begin
        r.status = bult_pkg::ST_FULL;
      end else begin
        r.status = bult_pkg::ST_SAVE;
        r.slot = bult_pkg::SLOT_W'(fill);
        log_mem[fill] = it.block_number;
        saved_mark[it.block_number] = 1'b1;
        fill++;
      end
    end else if (fill == 0) begin
      r.status = bult_pkg::ST_EMPTY;
    end else begin
      fill--;
      r.status = bult_pkg::ST_RESTORE;
      r.slot = bult_pkg::SLOT_W'(fill);
      r.restore_block = log_mem[fill];
      saved_mark[log_mem[fill]] = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      saved_mark = '{default: 1'b0};
      fill = 0;
      scan_by_bitmap = bult_pkg::BITMAP_MODE_RESET;
      cap_limit = bult_pkg::CAPACITY_LIMIT_RESET;
      awaited_answers.delete();
      failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bult_pkg::CFG_BITMAP_MODE) begin
          scan_by_bitmap = cfg_data[0];
        end else if (cfg_index == bult_pkg::CFG_CAPACITY_LIMIT) begin
          cap_limit = cfg_data[bult_pkg::LIMIT_W-1:0];
        end
      end
      if (result_valid && !result_stall) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, got %h", $time,
                   result);
          failures++;
        end else begin
          want = awaited_answers.pop_front();
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status,
                     result.status);
            failures++;
          end
          if (result.slot !== want.slot) begin
            $display("%0t: slot expected %0d, got %0d", $time, want.slot, result.slot);
            failures++;
          end
          if (result.restore_block !== want.restore_block) begin
            $display("%0t: restore_block expected %h, got %h", $time,
                     want.restore_block, result.restore_block);
            failures++;
          end
        end
      end
      if (item_valid && !item_stall) awaited_answers.push_back(undo_log_answer(item));
    end
    outstanding = awaited_answers.size();
  end

endmodule

[dv/tb.sv]
// Testbench top for the block undo log tracker: generates item, stall and
// configuration stimulus and gives the verdict. Depends on bult_pkg, the
// design and bult_answer_checker.
module tb;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  bult_pkg::item_t                  item = '0;
  logic                             result_valid;
  logic                             result_stall = 1'b0;
  bult_pkg::result_t                result;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bult_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bult_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  int                               failures;
  int                               outstanding;
  int                               idle_pct = 0;
  int                               stall_pct = 0;
  logic [bult_pkg::BLOCK_W-1:0]     block_pool [48];

  block_undo_log_tracker i_dut (.*);
  bult_answer_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) result_stall <= ($urandom_range(99) < stall_pct);

  task automatic send_request(bult_pkg::opcode_t op, logic [bult_pkg::BLOCK_W-1:0] blk);
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= '{opcode: op, block_number: blk};
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Stops offering items and waits until every answer has been received.
  task automatic drain();
    item_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic configure(bit mode, int cap);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= bult_pkg::CFG_BITMAP_MODE;
    cfg_data <= bult_pkg::CFG_DATA_W'(mode);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_index <= bult_pkg::CFG_CAPACITY_LIMIT;
    cfg_data <= bult_pkg::CFG_DATA_W'(cap);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit                           mode_plan [8] = '{1, 1, 0, 1, 0, 0, 1, 0};
    int                           cap_plan [8] = '{256, 511, 3, 0, 256, 300, 1, 128};
    int                           write_plan [8] = '{90, 90, 60, 70, 85, 85, 50, 55};
    bult_pkg::opcode_t            op;
    logic [bult_pkg::BLOCK_W-1:0] blk;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_request(bult_pkg::OP_POP, 16'h0000);
    send_request(bult_pkg::OP_WRITE, 16'h0000);
    send_request(bult_pkg::OP_WRITE, 16'h0000);
    send_request(bult_pkg::OP_WRITE, 16'hFFFF);
    send_request(bult_pkg::OP_WRITE, 16'h5555);
    send_request(bult_pkg::OP_POP, 16'h0000);
    send_request(bult_pkg::OP_WRITE, 16'h5555);
    configure(1'b1, 2);
    send_request(bult_pkg::OP_WRITE, 16'hAAAA);
    send_request(bult_pkg::OP_POP, 16'h0000);
    send_request(bult_pkg::OP_WRITE, 16'h1234);
    configure(1'b0, 2);
    send_request(bult_pkg::OP_WRITE, 16'hFFFF);
    send_request(bult_pkg::OP_WRITE, 16'h0000);
    configure(1'b0, 0);
    send_request(bult_pkg::OP_WRITE, 16'h0007);
    send_request(bult_pkg::OP_POP, 16'h0000);
    send_request(bult_pkg::OP_POP, 16'h0000);
    send_request(bult_pkg::OP_POP, 16'h0000);
    configure(1'b0, 511);
    send_request(bult_pkg::OP_WRITE, 16'hAAAA);
    send_request(bult_pkg::OP_WRITE, 16'hAAAA);
    configure(1'b1, 511);
    send_request(bult_pkg::OP_WRITE, 16'hAAAA);
    send_request(bult_pkg::OP_POP, 16'hFFFF);
    send_request(bult_pkg::OP_POP, 16'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      configure(mode_plan[ph], cap_plan[ph]);
      idle_pct = (ph % 4 == 1) ? 67 : (ph % 4 == 3) ? 32 : 0;
      stall_pct = (ph % 4 == 2) ? 67 : (ph % 4 == 3) ? 32 : 0;
      block_pool[0] = 16'h0000;
      block_pool[1] = 16'hFFFF;
      for (int i = 2; i < 48; i++) begin
        block_pool[i] = bult_pkg::BLOCK_W'($urandom_range(65535));
      end
      for (int n = 0; n < 235; n++) begin
        if (n == 117) drain();
        op = ($urandom_range(99) < write_plan[ph]) ? bult_pkg::OP_WRITE : bult_pkg::OP_POP;
        blk = ($urandom_range(99) < 60) ? block_pool[$urandom_range(47)]
                                        : bult_pkg::BLOCK_W'($urandom);
        send_request(op, blk);
      end
    end

    drain();
    idle_pct = 0;
    stall_pct = 0;
    repeat (20) @(negedge clk);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
design/bult_pkg.sv
design/bult_ram.sv
design/bult_dp.sv
design/bult_ctrl.sv
design/block_undo_log_tracker.sv
dv/bult_answer_checker.sv
dv/tb.sv
